/* src/dmc_pkg.sv */
// Shared types and constants of the direct-mapped cache tag controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

   localparam int MAX_SETS  = 1024;
   localparam int SET_BITS  = $clog2(MAX_SETS);
   localparam int ADDR_BITS = 32;
   localparam int TAG_BITS  = ADDR_BITS - 2;
   localparam int CNT_BITS  = SET_BITS + 1;

   localparam logic [3:0] OFS_MIN = 4'd2;
   localparam logic [3:0] OFS_MAX = 4'd8;
   localparam logic [3:0] IDX_MAX = 4'(SET_BITS);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   localparam logic [1:0] OC_HIT     = 2'd0;
   localparam logic [1:0] OC_FILL    = 2'd1;
   localparam logic [1:0] OC_REPLACE = 2'd2;
   localparam logic [1:0] OC_BYPASS  = 2'd3;

   localparam logic [2:0] CSR_SPLIT_MODE      = 3'd0;
   localparam logic [2:0] CSR_WRITE_BACK      = 3'd1;
   localparam logic [2:0] CSR_WRITE_ALLOCATE  = 3'd2;
   localparam logic [2:0] CSR_OFFSET_BITS     = 3'd3;
   localparam logic [2:0] CSR_DATA_INDEX_BITS = 3'd4;
   localparam logic [2:0] CSR_INST_INDEX_BITS = 3'd5;

   typedef struct packed {
      logic [1:0]           op;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [6:0]  fetch_words;
      logic [16:0] copy_back_words;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
   } data_line_type;

   typedef struct packed {
      logic                valid;
      logic [TAG_BITS-1:0] tag;
   } inst_line_type;

endpackage

`default_nettype wire

/* src/dmc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/direct_mapped_cache_tag_controller_unit.sv */
// Top level of the direct-mapped cache tag controller: lookup, update, flush walk.
// Depends on dmc_pkg and dmc_ram (one data line array, one instruction line array).
// Access: tag line read, then line update and result word load once the result slot is free.
// A new access is taken only in idle, after the read-then-write of one tag RAM line.
// Flush: walks 2^data_index_bits data sets, one set per cycle, then loads the result word.
// Reset: config takes defaults; a 1024-set sweep then clears both arrays, req_ready low.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_tag_controller_unit
   import dmc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [3:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic       split_ff, split_in;
   logic       wb_ff, wb_in;
   logic       wa_ff, wa_in;
   logic [3:0] ofs_ff, ofs_in;
   logic [3:0] dib_ff, dib_in;
   logic [3:0] iib_ff, iib_in;

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] dcnt_ff, dcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [1:0]          op_ff, op_in;
   logic                inst_ff, inst_in;
   logic [SET_BITS-1:0] idx_ff, idx_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   logic [3:0]          ob_c, dib_c, iib_c, ib_c;
   logic [6:0]          wpb;
   logic [CNT_BITS-1:0] set_cnt;
   logic                accept, req_inst, fire, rsp_load;
   logic [ADDR_BITS-1:0] addr_sh, tag_sh;
   logic [SET_BITS-1:0] idx_mask, req_idx;

   data_line_type       d_rdata, d_wdata;
   inst_line_type       i_rdata, i_wdata;
   logic                d_we, i_we, d_re, i_re, line_we;
   logic [SET_BITS-1:0] wr_addr, rd_addr;

   logic                ln_valid, ln_dirty, hit, is_store, bypass, new_dirty;
   rsp_type             look_rsp;

   // clamped configuration
   always_comb begin
      if (ofs_ff < OFS_MIN) begin
         ob_c = OFS_MIN;
      end else if (ofs_ff > OFS_MAX) begin
         ob_c = OFS_MAX;
      end else begin
         ob_c = ofs_ff;
      end
      dib_c   = (dib_ff > IDX_MAX) ? IDX_MAX : dib_ff;
      iib_c   = (iib_ff > IDX_MAX) ? IDX_MAX : iib_ff;
      wpb     = 7'd1 << (ob_c - OFS_MIN);
      set_cnt = CNT_BITS'(1) << dib_c;
   end

   // request decode
   always_comb begin
      accept   = req_valid && req_ready;
      req_inst = (req_data.op == OP_FETCH) && split_ff;
      ib_c     = req_inst ? iib_c : dib_c;
      addr_sh  = req_data.address >> ob_c;
      tag_sh   = req_data.address >> (5'(ob_c) + 5'(ib_c));
      idx_mask = ~({SET_BITS{1'b1}} << ib_c);
      req_idx  = addr_sh[SET_BITS-1:0] & idx_mask;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign fire      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lookup result
   always_comb begin
      ln_valid  = inst_ff ? i_rdata.valid : d_rdata.valid;
      ln_dirty  = inst_ff ? 1'b0 : d_rdata.dirty;
      hit       = ln_valid && ((inst_ff ? i_rdata.tag : d_rdata.tag) == tag_ff);
      is_store  = (op_ff == OP_STORE);
      bypass    = !hit && is_store && !wa_ff;
      new_dirty = is_store && wb_ff;
      look_rsp  = '0;
      if (hit) begin
         look_rsp.outcome = OC_HIT;
         look_rsp.copy_back_words = 17'(is_store && !wb_ff);
      end else if (bypass) begin
         look_rsp.outcome = OC_BYPASS;
         look_rsp.copy_back_words = 17'd1;
      end else begin
         look_rsp.outcome     = ln_valid ? OC_REPLACE : OC_FILL;
         look_rsp.fetch_words = wpb;
         look_rsp.copy_back_words = ((ln_valid && ln_dirty) ? 17'(wpb) : 17'd0)
                                  + 17'(is_store && !wb_ff);
      end
      d_wdata.valid = 1'b1;
      d_wdata.dirty = hit ? (ln_dirty || new_dirty) : new_dirty;
      d_wdata.tag   = tag_ff;
      i_wdata.valid = 1'b1;
      i_wdata.tag   = tag_ff;
      if (state_ff == ST_CLEAR) begin
         d_wdata = '0;
         i_wdata = '0;
      end
   end

   // memory control; a flush starts its walk at set 0
   always_comb begin
      line_we = (state_ff == ST_LOOK) && fire && !bypass;
      d_we    = (state_ff == ST_CLEAR) || (line_we && !inst_ff);
      i_we    = (state_ff == ST_CLEAR) || (line_we && inst_ff);
      wr_addr = (state_ff == ST_CLEAR) ? cnt_ff[SET_BITS-1:0] : idx_ff;
      if (state_ff == ST_IDLE) begin
         rd_addr = (req_data.op == OP_FLUSH) ? '0 : req_idx;
      end else begin
         rd_addr = cnt_ff[SET_BITS-1:0];
      end
      d_re    = (accept && !req_inst) || (state_ff == ST_FLUSH);
      i_re    = accept && req_inst;
   end

   dmc_ram #(.WIDTH($bits(data_line_type)), .DEPTH(MAX_SETS)) u_data_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (wr_addr),
      .wr_data (d_wdata),
      .rd_en   (d_re),
      .rd_addr (rd_addr),
      .rd_data (d_rdata)
   );

   dmc_ram #(.WIDTH($bits(inst_line_type)), .DEPTH(MAX_SETS)) u_inst_ram (
      .clock   (clock),
      .wr_en   (i_we),
      .wr_addr (wr_addr),
      .wr_data (i_wdata),
      .rd_en   (i_re),
      .rd_addr (rd_addr),
      .rd_data (i_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dcnt_in      = dcnt_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      inst_in      = inst_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[SET_BITS-1:0] == SET_BITS'(MAX_SETS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_data.op;
               inst_in = req_inst;
               idx_in  = req_idx;
               tag_in  = tag_sh[TAG_BITS-1:0];
               if (req_data.op == OP_FLUSH) begin
                  cnt_in   = CNT_BITS'(1);
                  dcnt_in  = '0;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (fire) begin
               rsp_load    = 1'b1;
               rsp_data_in = look_rsp;
               state_in    = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            dcnt_in = dcnt_ff + CNT_BITS'(d_rdata.valid && d_rdata.dirty);
            if (cnt_ff == set_cnt) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (fire) begin
               rsp_load    = 1'b1;
               rsp_data_in.outcome         = OC_HIT;
               rsp_data_in.fetch_words     = '0;
               rsp_data_in.copy_back_words = 17'(dcnt_ff) << (ob_c - OFS_MIN);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // configuration
   always_comb begin
      split_in = split_ff;
      wb_in    = wb_ff;
      wa_in    = wa_ff;
      ofs_in   = ofs_ff;
      dib_in   = dib_ff;
      iib_in   = iib_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPLIT_MODE:      split_in = csr_wdata[0];
            CSR_WRITE_BACK:      wb_in    = csr_wdata[0];
            CSR_WRITE_ALLOCATE:  wa_in    = csr_wdata[0];
            CSR_OFFSET_BITS:     ofs_in   = csr_wdata;
            CSR_DATA_INDEX_BITS: dib_in   = csr_wdata;
            CSR_INST_INDEX_BITS: iib_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         split_ff     <= 1'b0;
         wb_ff        <= 1'b1;
         wa_ff        <= 1'b1;
         ofs_ff       <= 4'd4;
         dib_ff       <= 4'd8;
         iib_ff       <= 4'd8;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         split_ff     <= split_in;
         wb_ff        <= wb_in;
         wa_ff        <= wa_in;
         ofs_ff       <= ofs_in;
         dib_ff       <= dib_in;
         iib_ff       <= iib_in;
      end
   end

   always_ff @(posedge clock) begin
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      inst_ff     <= inst_in;
      idx_ff      <= idx_in;
      tag_ff      <= tag_in;
   end

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing sweep");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOK) || (state_ff == ST_FLUSH))
      else $error("accepted word not processed");

   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (cnt_ff <= set_cnt) && (cnt_ff != '0))
      else $error("flush walk out of range");

   a_write_when: assert property (@(posedge clock) disable iff (reset)
      (d_we || i_we) |-> (state_ff == ST_CLEAR) || ((state_ff == ST_LOOK) && fire))
      else $error("line written outside update");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwrites pending word");

endmodule

`default_nettype wire
